// ----- rtl/http_chunked_body_decoder_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Shared concurrent checks, clocked on clk and held off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication
`define HCBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hcbd_pkg.sv -----
// ---------------------------------------------------------------------------
// hcbd_pkg
// Types, constants and byte helpers of the chunked body decoder.
// ---------------------------------------------------------------------------
package hcbd_pkg;

	// Width of the internal size and length counters
	localparam int LEN_BITS = 22;
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

	// Reported length field
	localparam int OUT_LEN_W = 22;
	localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX = {OUT_LEN_W{1'b1}};

	// Stream payload widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Register map
	localparam int APB_AW = 3;
	localparam logic REG_DECHUNK_ENABLE = 1'b0;

	// Result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_EARLY_END = 2'd2;

	// Characters
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_T  = 8'h74;

	// Header marker, first character in the top byte
	localparam int MARKER_LEN = 26;
	localparam logic [8*MARKER_LEN-1:0] MARKER_TEXT = "transfer-encoding: chunked";

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_PASS   = 3'd1,
		PH_SIZE   = 3'd2,
		PH_EXT    = 3'd3,
		PH_DATA   = 3'd4,
		PH_TRAIL  = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef struct packed {
		logic                  kind;
		logic [OUT_DATA_W-1:0] data;
	} result_t;

	// Marker character at position idx (idx below MARKER_LEN)
	function automatic logic [7:0] marker_char(input logic [4:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		for (int i = 0; i < MARKER_LEN; i++) begin
			if (idx == 5'(i)) begin
				ch = MARKER_TEXT[8*(MARKER_LEN-1-i) +: 8];
			end
		end
		return ch;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'd32) : b;
	endfunction

	// Hex digit decode: bit 4 marks a valid digit
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		if ((b >= 8'h30) && (b <= 8'h39)) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if ((b >= 8'h61) && (b <= 8'h66)) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if ((b >= 8'h41) && (b <= 8'h46)) begin
			r = {1'b1, 4'(b - 8'h37)};
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

endpackage

// ----- rtl/http_chunked_body_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Finds the end of an HTTP response header, spots a chunked transfer
// marker and strips chunk framing from the body, one byte per transfer.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Signals                          Payload
// s_*       in   s_tvalid s_tready s_tdata s_tlast  response byte, last flag
// m_*       out  m_tvalid m_tready m_tdata m_tuser  body byte or end report
// APB       in   psel penable pwrite paddr pwdata   dechunk_enable at 0x0
//
// One byte per cycle while the queue has room: a byte waits in the input
// register, and the state update for it pushes up to two results into a
// 4-entry queue. A byte carrying s_tlast adds an end report after any data
// result. s_tready is low only while a byte waits and fewer than two queue
// slots are free. Reset clears the parser state and the queue and sets
// dechunk_enable to 1. After an end report the parser restarts.
// ---------------------------------------------------------------------------
`include "http_chunked_body_decoder_unit_assert.svh"

module http_chunked_body_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hcbd_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] in_byte
	input  logic                              s_tlast,  // last_byte
	// Output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] out_byte, [29:8] body_length, [30] chunked_seen, [32:31] status
	output logic [hcbd_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tuser,  // [0] kind
	// Configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hcbd_pkg::APB_AW-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int LB = hcbd_pkg::LEN_BITS;

	// Input register
	logic                                 valid_s1;
	logic [7:0]                           byte_s1;
	logic                                 last_s1;

	// Parser state
	hcbd_pkg::phase_t                     phase_q, phase_d;
	logic [1:0]                           emc_q, emc_d;
	logic [4:0]                           midx_q, midx_d;
	logic                                 chunked_q, chunked_d;
	logic [LB-1:0]                        acc_q, acc_d;
	logic [LB-1:0]                        remain_q, remain_d;
	logic [LB-1:0]                        count_emit_q, count_emit_d;
	logic [1:0]                           err_q, err_d;
	logic                                 dechunk_q;

	// Result queue
	hcbd_pkg::result_t                    fifo_q [hcbd_pkg::FIFO_DEPTH];
	logic [hcbd_pkg::FIFO_AW-1:0]         wr_ptr_q, rd_ptr_q;
	logic [hcbd_pkg::FIFO_AW:0]           level_q;

	logic                                 advance;
	logic                                 pop;
	logic [1:0]                           push_cnt;
	hcbd_pkg::result_t                    res0, res1;
	logic                                 cfg_write;

	// Configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = {31'd0, dechunk_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dechunk_q <= 1'b1;
		end else if (cfg_write && (paddr[2] == hcbd_pkg::REG_DECHUNK_ENABLE)) begin
			dechunk_q <= pwdata[0];
		end
	end

	// Input handshake: hold the byte until the queue has room for two results
	assign advance  = valid_s1 && (level_q <= (hcbd_pkg::FIFO_AW+1)'(hcbd_pkg::FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	// Parser: next state and results for the byte in the input register
	always_comb begin
		logic [7:0]          lc;
		logic [4:0]          idx;
		logic [7:0]          expect_ch;
		logic [2:0]          c;
		logic [4:0]          hd;
		logic [LB-1:0]       rem_dec;
		logic                data_out;
		logic [1:0]          rep_status;
		logic [hcbd_pkg::OUT_LEN_W-1:0] len_out;
		logic [hcbd_pkg::OUT_LEN_W-1:0] len_rep;

		phase_d      = phase_q;
		emc_d        = emc_q;
		midx_d       = midx_q;
		chunked_d    = chunked_q;
		acc_d        = acc_q;
		remain_d     = remain_q;
		count_emit_d = count_emit_q;
		err_d        = err_q;
		data_out     = 1'b0;
		lc           = hcbd_pkg::to_lower(byte_s1);
		idx          = (midx_q < 5'(hcbd_pkg::MARKER_LEN)) ? midx_q : 5'd0;
		expect_ch    = emc_q[0] ? hcbd_pkg::CH_LF : hcbd_pkg::CH_CR;
		c            = 3'(emc_q) + 3'd1;
		hd           = hcbd_pkg::hex_digit(byte_s1);
		rem_dec      = (remain_q != '0) ? (remain_q - LB'(1)) : remain_q;

		case (phase_q)
			hcbd_pkg::PH_HEADER: begin
				// Match the marker while not yet seen
				if (!chunked_q) begin
					if (lc == hcbd_pkg::marker_char(idx)) begin
						if (idx == 5'(hcbd_pkg::MARKER_LEN - 1)) begin
							chunked_d = 1'b1;
							midx_d    = 5'd0;
						end else begin
							midx_d = idx + 5'd1;
						end
					end else begin
						midx_d = (lc == hcbd_pkg::CH_T) ? 5'd1 : 5'd0;
					end
				end
				// Track CR LF CR LF
				if (byte_s1 == expect_ch) begin
					if (c == 3'd4) begin
						emc_d   = 2'd0;
						acc_d   = '0;
						phase_d = (dechunk_q && chunked_d) ? hcbd_pkg::PH_SIZE
						                                   : hcbd_pkg::PH_PASS;
					end else begin
						emc_d = c[1:0];
					end
				end else begin
					emc_d = (byte_s1 == hcbd_pkg::CH_CR) ? 2'd1 : 2'd0;
				end
			end
			hcbd_pkg::PH_PASS: begin
				data_out = 1'b1;
			end
			hcbd_pkg::PH_SIZE: begin
				// Accumulate hex digits, flag a size that does not fit
				if (hd[4]) begin
					if (acc_q[LB-1 -: 4] != 4'd0) begin
						err_d   = hcbd_pkg::ST_TOO_LARGE;
						phase_d = hcbd_pkg::PH_DONE;
					end else begin
						acc_d = {acc_q[LB-5:0], hd[3:0]};
					end
				end else begin
					phase_d = hcbd_pkg::PH_EXT;
					emc_d   = (byte_s1 == hcbd_pkg::CH_CR) ? 2'd1 : 2'd0;
				end
			end
			hcbd_pkg::PH_EXT: begin
				// Skip the rest of the size line up to CR LF
				if ((emc_q == 2'd1) && (byte_s1 == hcbd_pkg::CH_LF)) begin
					emc_d = 2'd0;
					if (acc_q == '0) begin
						phase_d = hcbd_pkg::PH_DONE;
					end else begin
						remain_d = acc_q;
						phase_d  = hcbd_pkg::PH_DATA;
					end
				end else begin
					emc_d = (byte_s1 == hcbd_pkg::CH_CR) ? 2'd1 : 2'd0;
				end
			end
			hcbd_pkg::PH_DATA: begin
				data_out = 1'b1;
				remain_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = hcbd_pkg::PH_TRAIL;
					emc_d   = 2'd0;
				end
			end
			hcbd_pkg::PH_TRAIL: begin
				// Drop the two bytes after chunk data
				if (emc_q >= 2'd1) begin
					emc_d   = 2'd0;
					acc_d   = '0;
					phase_d = hcbd_pkg::PH_SIZE;
				end else begin
					emc_d = emc_q + 2'd1;
				end
			end
			default: begin
			end
		endcase

		// Count emitted bytes, saturating
		if (data_out && (count_emit_q != hcbd_pkg::LEN_MAX)) begin
			count_emit_d = count_emit_q + LB'(1);
		end

		if ((33'(count_emit_d)) > (33'(hcbd_pkg::OUT_LEN_MAX))) begin
			len_out = hcbd_pkg::OUT_LEN_MAX;
		end else begin
			len_out = hcbd_pkg::OUT_LEN_W'(count_emit_d);
		end
		len_rep = len_out;

		rep_status = err_d;
		if ((err_d == hcbd_pkg::ST_OK) && (phase_d >= hcbd_pkg::PH_SIZE) &&
		    (phase_d <= hcbd_pkg::PH_TRAIL)) begin
			rep_status = hcbd_pkg::ST_EARLY_END;
		end

		// Build results: data byte first, end report after it
		res0.kind = hcbd_pkg::KIND_DATA;
		res0.data = {7'd0, err_d, chunked_d, len_out, byte_s1};
		res1.kind = hcbd_pkg::KIND_REPORT;
		res1.data = {7'd0, rep_status, chunked_d, len_rep, 8'd0};
		if (!data_out) begin
			res0 = res1;
		end
		push_cnt = advance ? (2'(data_out) + 2'(last_s1)) : 2'd0;

		// Start a new response after the end report
		if (last_s1) begin
			phase_d      = hcbd_pkg::PH_HEADER;
			emc_d        = 2'd0;
			midx_d       = 5'd0;
			chunked_d    = 1'b0;
			acc_d        = '0;
			remain_d     = '0;
			count_emit_d = '0;
			err_d        = hcbd_pkg::ST_OK;
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= hcbd_pkg::PH_HEADER;
			emc_q        <= 2'd0;
			midx_q       <= 5'd0;
			chunked_q    <= 1'b0;
			acc_q        <= '0;
			remain_q     <= '0;
			count_emit_q <= '0;
			err_q        <= hcbd_pkg::ST_OK;
		end else if (advance) begin
			phase_q      <= phase_d;
			emc_q        <= emc_d;
			midx_q       <= midx_d;
			chunked_q    <= chunked_d;
			acc_q        <= acc_d;
			remain_q     <= remain_d;
			count_emit_q <= count_emit_d;
			err_q        <= err_d;
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (push_cnt == 2'd2) begin
			fifo_q[wr_ptr_q + hcbd_pkg::FIFO_AW'(1)] <= res1;
		end
	end

	// Result queue pointers and fill level
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + hcbd_pkg::FIFO_AW'(push_cnt);
			rd_ptr_q <= rd_ptr_q + hcbd_pkg::FIFO_AW'(pop);
			level_q  <= level_q + (hcbd_pkg::FIFO_AW+1)'(push_cnt)
			                    - (hcbd_pkg::FIFO_AW+1)'(pop);
		end
	end

	assign m_tvalid = (level_q != '0);
	assign m_tdata  = fifo_q[rd_ptr_q].data;
	assign m_tuser  = fifo_q[rd_ptr_q].kind;

	// Checks
	`HCBD_ASSERT_NOW(a_level_bound, 1'b1, level_q <= (hcbd_pkg::FIFO_AW+1)'(hcbd_pkg::FIFO_DEPTH), "result queue overfilled")
	`HCBD_ASSERT_NEXT(a_restart_after_last, advance && last_s1, phase_q == hcbd_pkg::PH_HEADER && count_emit_q == '0, "parser did not restart after end report")
	`HCBD_ASSERT_NOW(a_chunked_phase, phase_q == hcbd_pkg::PH_SIZE || phase_q == hcbd_pkg::PH_EXT || phase_q == hcbd_pkg::PH_DATA || phase_q == hcbd_pkg::PH_TRAIL, chunked_q, "chunk decoding without marker")
	`HCBD_ASSERT_NOW(a_data_remaining, phase_q == hcbd_pkg::PH_DATA, remain_q != '0, "chunk data phase with nothing left")

endmodule
